// ===== hdl/pkle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkle_pkg: shared types and constants for the packed key list engine
// Operation codes, status codes, table geometry and the memory request type.
// ----------------------------------------------------------------------------
package pkle_pkg;

  localparam int TABLE_SIZE = 32;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_LFIND   = 3'd2,
    OP_BFIND   = 3'd3,
    OP_DEL_AT  = 3'd4,
    OP_DEL_KEY = 3'd5,
    OP_SORT    = 3'd6,
    OP_READ    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    key_t wdata;
    idx_t raddr;
  } mem_req_t;

endpackage

// ===== hdl/pkle_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkle_in_if / pkle_out_if: valid/ready channels of the key list engine
// Request words carry an operation; response words carry its result.
// ----------------------------------------------------------------------------
interface pkle_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic signed [31:0] key_value;
  logic [4:0]  slot_index;
  modport source (output valid, kind, key_value, slot_index, input ready);
  modport sink (input valid, kind, key_value, slot_index, output ready);
endinterface

interface pkle_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  found_place;
  logic signed [31:0] read_value;
  logic [5:0]  occupied_count;
  modport source (output valid, status, found_place, read_value, occupied_count,
                  input ready);
  modport sink (input valid, status, found_place, read_value, occupied_count,
                output ready);
endinterface

// ===== hdl/pkle_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkle_ram: key table storage
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module pkle_ram (
  input  logic              clk,
  input  pkle_pkg::mem_req_t req,
  output pkle_pkg::key_t    rdata
);
  import pkle_pkg::*;

  key_t mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

// ===== hdl/pkle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkle_ctrl: operation sequencer
// Clears the table after reset, then runs each operation as passes over the
// table memory, one read and at most one write per cycle.
// ----------------------------------------------------------------------------
module pkle_ctrl (
  input  logic clk,
  input  logic rst,
  pkle_in_if.sink   req,
  pkle_out_if.source rsp,
  output pkle_pkg::mem_req_t mreq,
  input  pkle_pkg::key_t     rdata
);
  import pkle_pkg::*;

  typedef enum logic [18:0] {
    S_CLEAR    = 19'h00001,
    S_IDLE     = 19'h00002,
    S_PREFIX   = 19'h00004,   // find prefix length
    S_EXEC     = 19'h00008,   // dispatch once prefix known
    S_LIN      = 19'h00010,   // linear probe stream
    S_BIN_PR   = 19'h00020,   // binary probe: issue read of mid
    S_BIN_CMP  = 19'h00040,   // binary probe: compare
    S_RD_WAIT  = 19'h00080,
    S_INS_FWD  = 19'h00100,   // search empty slot forward from pos
    S_INS_BWD  = 19'h00200,   // search empty slot backward from pos-1
    S_SH_RD    = 19'h00400,   // shift: read neighbor or place key
    S_SH_WR    = 19'h00800,   // shift: write neighbor
    S_COMP     = 19'h01000,   // compaction pass
    S_FILL     = 19'h02000,   // zero fill of the tail
    S_SORT_LD  = 19'h04000,
    S_SORT_GV  = 19'h08000,
    S_SORT_RJ  = 19'h10000,
    S_SORT_CMP = 19'h20000,
    S_COUNT    = 19'h40000    // closing prefix count
  } state_t;

  typedef logic signed [CNT_W:0] sidx_t;

  state_t  state;
  op_t     op;
  key_t    key;
  idx_t    pos;
  logic    pos_bad;
  status_t status;
  cnt_t    place;
  key_t    rdv;
  // scan machinery
  cnt_t    ri;          // next read index
  idx_t    rq;          // address whose data is on rdata when rv is set
  logic    rv;
  cnt_t    w;           // compaction write pointer
  cnt_t    n;           // prefix length
  idx_t    e;           // empty slot for insert
  idx_t    cur;         // shift position
  sidx_t   lo, hi;
  // insertion sort
  cnt_t    si;
  sidx_t   sj;
  key_t    sv;
  logic    post_sort;

  sidx_t mid;
  logic  rd_zero;
  logic  last_rq;
  logic  cnt_hit;

  assign mid     = lo + ((hi - lo) >>> 1);
  assign rd_zero = (rdata == '0);
  assign last_rq = (rq == idx_t'(TABLE_SIZE - 1));
  assign cnt_hit = rv && (rd_zero || last_rq);

  assign req.ready = (state == S_IDLE) && !rsp.valid;

  // table port
  always_comb begin
    mreq.we    = 1'b0;
    mreq.waddr = '0;
    mreq.wdata = '0;
    mreq.raddr = ri[IDX_W-1:0];
    case (state)
      S_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.waddr = ri[IDX_W-1:0];
      end
      S_EXEC: begin
        case (op)
          OP_APPEND: begin
            if (n != cnt_t'(TABLE_SIZE)) begin
              mreq.we    = 1'b1;
              mreq.waddr = n[IDX_W-1:0];
              mreq.wdata = key;
            end
          end
          OP_DEL_AT: begin
            if (!pos_bad) begin
              mreq.we    = 1'b1;
              mreq.waddr = pos;
            end
          end
          OP_READ: mreq.raddr = pos;
          default: mreq.we = 1'b0;
        endcase
      end
      S_LIN: begin
        if (rv && rdata == key && op == OP_DEL_KEY) begin
          mreq.we    = 1'b1;
          mreq.waddr = rq;
        end
      end
      S_BIN_PR: mreq.raddr = mid[IDX_W-1:0];
      S_SH_RD: begin
        if (cur == pos) begin
          mreq.we    = 1'b1;
          mreq.waddr = pos;
          mreq.wdata = key;
        end else begin
          mreq.raddr = (e > pos) ? cur - idx_t'(1) : cur + idx_t'(1);
        end
      end
      S_SH_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = cur;
        mreq.wdata = rdata;
      end
      S_COMP: begin
        if (rv && !rd_zero) begin
          mreq.we    = 1'b1;
          mreq.waddr = w[IDX_W-1:0];
          mreq.wdata = rdata;
        end
      end
      S_FILL: begin
        if (w < cnt_t'(TABLE_SIZE)) begin
          mreq.we    = 1'b1;
          mreq.waddr = w[IDX_W-1:0];
        end
      end
      S_SORT_LD: mreq.raddr = si[IDX_W-1:0];
      S_SORT_RJ: begin
        if (sj < 0) begin
          mreq.we    = 1'b1;
          mreq.waddr = idx_t'(sj + sidx_t'(1));
          mreq.wdata = sv;
        end else begin
          mreq.raddr = sj[IDX_W-1:0];
        end
      end
      S_SORT_CMP: begin
        mreq.we    = 1'b1;
        mreq.waddr = idx_t'(sj + sidx_t'(1));
        mreq.wdata = (rdata > sv) ? rdata : sv;
      end
      default: mreq.we = 1'b0;
    endcase
  end

  // response valid: raise on the closing count, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_COUNT && cnt_hit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ri    <= '0;
      rv    <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          ri <= ri + cnt_t'(1);
          if (ri == cnt_t'(TABLE_SIZE - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            op        <= op_t'(req.kind);
            key       <= req.key_value;
            pos       <= idx_t'(req.slot_index);
            pos_bad   <= (32'(req.slot_index) >= TABLE_SIZE);
            status    <= ST_OK;
            place     <= '0;
            rdv       <= '0;
            ri        <= '0;
            rv        <= 1'b0;
            w         <= '0;
            post_sort <= 1'b0;
            state     <= S_PREFIX;
          end
        end
        S_PREFIX: begin
          if (cnt_hit) begin
            n     <= rd_zero ? cnt_t'(rq) : cnt_t'(TABLE_SIZE);
            rv    <= 1'b0;
            state <= S_EXEC;
          end else begin
            rq <= ri[IDX_W-1:0];
            rv <= 1'b1;
            ri <= ri + cnt_t'(1);
          end
        end
        S_EXEC: begin
          rv <= 1'b0;
          ri <= (op == OP_INSERT && !pos_bad) ? cnt_t'(pos) : '0;
          case (op)
            OP_APPEND: begin
              if (n == cnt_t'(TABLE_SIZE)) status <= ST_FULL;
              state <= S_COUNT;
            end
            OP_LFIND, OP_DEL_KEY: begin
              if (n == '0) begin
                status <= ST_NOT_FOUND;
                state  <= S_COUNT;
              end else begin
                state <= S_LIN;
              end
            end
            OP_BFIND: begin
              lo    <= '0;
              hi    <= $signed({1'b0, n}) - sidx_t'(1);
              state <= S_BIN_PR;
            end
            OP_READ: begin
              if (pos_bad) begin
                status <= ST_RANGE;
                state  <= S_COUNT;
              end else begin
                state <= S_RD_WAIT;
              end
            end
            OP_DEL_AT: begin
              if (pos_bad) begin
                status <= ST_RANGE;
                state  <= S_COUNT;
              end else begin
                state <= S_COMP;
              end
            end
            OP_SORT: begin
              post_sort <= 1'b1;
              state     <= S_COMP;
            end
            OP_INSERT: begin
              if (pos_bad) begin
                status <= ST_RANGE;
                state  <= S_COUNT;
              end else begin
                state <= S_INS_FWD;
              end
            end
            default: state <= S_COUNT;
          endcase
        end
        S_LIN: begin
          if (rv && rdata == key) begin
            place <= cnt_t'(rq) + cnt_t'(1);
            rv    <= 1'b0;
            ri    <= '0;
            state <= (op == OP_DEL_KEY) ? S_COMP : S_COUNT;
          end else if (rv && cnt_t'(rq) + cnt_t'(1) == n) begin
            status <= ST_NOT_FOUND;
            rv     <= 1'b0;
            ri     <= '0;
            state  <= S_COUNT;
          end else begin
            rq <= ri[IDX_W-1:0];
            rv <= 1'b1;
            ri <= ri + cnt_t'(1);
          end
        end
        S_BIN_PR: begin
          if (lo > hi) begin
            status <= ST_NOT_FOUND;
            state  <= S_COUNT;
          end else begin
            rq    <= mid[IDX_W-1:0];
            state <= S_BIN_CMP;
          end
        end
        S_BIN_CMP: begin
          if (rdata == key) begin
            place <= cnt_t'(rq) + cnt_t'(1);
            state <= S_COUNT;
          end else begin
            if (rdata > key) hi <= $signed({1'b0, cnt_t'(rq)}) - sidx_t'(1);
            else lo <= $signed({1'b0, cnt_t'(rq)}) + sidx_t'(1);
            state <= S_BIN_PR;
          end
        end
        S_RD_WAIT: begin
          rdv   <= rdata;
          state <= S_COUNT;
        end
        S_INS_FWD: begin
          if (rv && rd_zero) begin
            e     <= rq;
            cur   <= rq;
            rv    <= 1'b0;
            state <= S_SH_RD;
          end else if (rv && last_rq) begin
            rv <= 1'b0;
            if (pos == '0) begin
              status <= ST_FULL;
              ri     <= '0;
              state  <= S_COUNT;
            end else begin
              ri    <= cnt_t'(pos) - cnt_t'(1);
              state <= S_INS_BWD;
            end
          end else begin
            rq <= ri[IDX_W-1:0];
            rv <= 1'b1;
            ri <= ri + cnt_t'(1);
          end
        end
        S_INS_BWD: begin
          if (rv && rd_zero) begin
            e     <= rq;
            cur   <= rq;
            rv    <= 1'b0;
            state <= S_SH_RD;
          end else if (rv && rq == '0) begin
            status <= ST_FULL;
            rv     <= 1'b0;
            ri     <= '0;
            state  <= S_COUNT;
          end else begin
            rq <= ri[IDX_W-1:0];
            rv <= 1'b1;
            ri <= ri - cnt_t'(1);
          end
        end
        S_SH_RD: begin
          // key lands at pos once the walk from the empty slot arrives
          if (cur == pos) begin
            ri    <= '0;
            state <= S_COUNT;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          cur   <= (e > pos) ? cur - idx_t'(1) : cur + idx_t'(1);
          state <= S_SH_RD;
        end
        S_COMP: begin
          // writes trail the reads, so no entry is read after it is moved
          if (rv && !rd_zero) w <= w + cnt_t'(1);
          if (rv && last_rq) begin
            n     <= rd_zero ? w : w + cnt_t'(1);
            rv    <= 1'b0;
            state <= S_FILL;
          end else begin
            rq <= ri[IDX_W-1:0];
            rv <= 1'b1;
            ri <= ri + cnt_t'(1);
          end
        end
        S_FILL: begin
          if (w < cnt_t'(TABLE_SIZE)) begin
            w <= w + cnt_t'(1);
          end else begin
            ri <= '0;
            if (post_sort) begin
              si    <= cnt_t'(1);
              state <= S_SORT_LD;
            end else begin
              state <= S_COUNT;
            end
          end
        end
        S_SORT_LD: begin
          if (si >= n) state <= S_COUNT;
          else state <= S_SORT_GV;
        end
        S_SORT_GV: begin
          sv    <= rdata;
          sj    <= $signed({1'b0, si}) - sidx_t'(1);
          state <= S_SORT_RJ;
        end
        S_SORT_RJ: begin
          if (sj < 0) begin
            si    <= si + cnt_t'(1);
            state <= S_SORT_LD;
          end else begin
            state <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          if (rdata > sv) begin
            sj    <= sj - sidx_t'(1);
            state <= S_SORT_RJ;
          end else begin
            si    <= si + cnt_t'(1);
            state <= S_SORT_LD;
          end
        end
        S_COUNT: begin
          if (cnt_hit) begin
            rv                 <= 1'b0;
            rsp.status         <= status;
            rsp.found_place    <= place;
            rsp.read_value     <= rdv;
            rsp.occupied_count <= rd_zero ? cnt_t'(rq) : cnt_t'(TABLE_SIZE);
            state              <= S_IDLE;
          end else begin
            rq <= ri[IDX_W-1:0];
            rv <= 1'b1;
            ri <= ri + cnt_t'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found_place != '0 |-> rsp.status == ST_OK);
  ap_read_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.read_value == '0)
    else $error("read value not zero on failure");
  ap_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.occupied_count <= 6'(TABLE_SIZE))
    else $error("count beyond table");
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.occupied_count))
    else $error("response word changed while stalled");
endmodule

// ===== hdl/packed_key_list_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_key_list_engine_unit: key table with append, insert, search, delete,
// sort and read
// ----------------------------------------------------------------------------
// The table lives in one 32-entry memory with one read and one write port.
// After reset a clearing pass zeroes it; no word is accepted until then.
// One request word is handled at a time and the next is held off until the
// response word has been taken: each operation scans the table in memory
// passes (a prefix count, then search, shift or compaction, then a closing
// prefix recount); sort compacts, then runs an insertion sort.
module packed_key_list_engine_unit (
  input logic clk,
  input logic rst,
  pkle_in_if.sink    req,
  pkle_out_if.source rsp
);
  import pkle_pkg::*;

  mem_req_t mreq;
  key_t     rdata;

  // sequencer: owns both channels and drives the table port
  pkle_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .mreq  (mreq),
    .rdata (rdata)
  );

  // table storage
  pkle_ram u_ram (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );
endmodule
